>>> src/polar_table_bilinear_speed_assert.svh
// Assertion macros shared by the polar speed table RTL.
`ifndef POLAR_TABLE_BILINEAR_SPEED_ASSERT_SVH
`define POLAR_TABLE_BILINEAR_SPEED_ASSERT_SVH
`ifndef ASSERT_OFF
`define PTBS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define PTBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define PTBS_ASSERT_IMPL(label, ante, cons)
`define PTBS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> src/ptbs_pkg.sv
// Shared types, codes and widths for the polar speed table.
package ptbs_pkg;

    // Transaction kinds carried in tuser
    localparam logic [1:0] FUNC_WR_ANGLE = 2'd0;
    localparam logic [1:0] FUNC_WR_WIND  = 2'd1;
    localparam logic [1:0] FUNC_WR_CELL  = 2'd2;
    localparam logic [1:0] FUNC_QUERY    = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_ANGLE_COUNT = 2'd0;
    localparam logic [1:0] CFG_WIND_COUNT  = 2'd1;

    // Angle wrap and fold constants, 1/16 degree
    localparam logic signed [16:0] ANG_FULL = 17'sd5760;
    localparam logic signed [16:0] ANG_HALF = 17'sd2880;

    // Multiply-divide unit widths
    localparam int A_W = 36;
    localparam int B_W = 18;
    localparam int D_W = 18;
    localparam int P_W = A_W + B_W;
    localparam int V_W = P_W + 1;

    typedef struct packed {
        logic                  start;
        logic signed [A_W-1:0] a;
        logic signed [B_W-1:0] b;
        logic signed [D_W-1:0] d;
    } md_req_t;

    typedef struct packed {
        logic                  done;
        logic signed [V_W-1:0] q;
    } md_rsp_t;

endpackage

>>> src/polar_table_bilinear_speed.sv
// Write transactions go from acceptance through S_DONE to the output register.
// Queries walk the angle and wind axes and then interpolate; the shared
// multiply-divide unit (shift-add multiply, then restoring divide) does each step.
// One transaction is in work at a time; the output register frees the input.
// Reset (rst_n, asynchronous, active low) clears control and sets both counts
// to 1; the axis and speed memories hold no reset value and need no clearing.
`include "polar_table_bilinear_speed_assert.svh"

module polar_table_bilinear_speed
#(
    parameter int MAX_ANGLES = 64,
    parameter int MAX_WINDS  = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // angle_slot[5:0], wind_slot[10:6], write_value[26:11], query_angle[42:27],
    // query_wind[58:43], check_wind_range[59], zero[63:60]
    input  logic [63:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // boat_speed[15:0]
    output logic [15:0] m_axis_tdata,
    // speed_valid[0]
    output logic [0:0]  m_axis_tuser,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [6:0]  cfg_wdata
);

    localparam int AIDX_W = $clog2(MAX_ANGLES);
    localparam int WIDX_W = $clog2(MAX_WINDS);
    localparam int CA_W   = $clog2(MAX_ANGLES * MAX_WINDS);
    localparam int V_W    = ptbs_pkg::V_W;

    typedef enum logic [3:0] {
        S_IDLE, S_WRAP, S_RD0, S_RD1, S_CHK, S_ASCAN, S_WSTART,
        S_WSCAN, S_FETCH, S_LIN, S_WAIT, S_DONE
    } state_t;

    // Storage
    logic [11:0] angle_mem [MAX_ANGLES];
    logic [15:0] wind_mem  [MAX_WINDS];
    logic [15:0] speed_mem [MAX_ANGLES * MAX_WINDS];

    logic [11:0] a_rd_data;
    logic [15:0] w_rd_data;
    logic [15:0] s_rd_data;
    logic [AIDX_W-1:0] a_raddr;
    logic [WIDX_W-1:0] w_raddr;
    logic [CA_W-1:0]   s_raddr;

    state_t             state_reg;
    logic [6:0]         angle_count_reg;
    logic [5:0]         wind_count_reg;
    logic signed [16:0] ang_reg;
    logic [14:0]        qw_reg;
    logic               chk_reg;
    logic [AIDX_W-1:0]  na_last_reg;
    logic [WIDX_W-1:0]  nw_last_reg;
    logic [AIDX_W-1:0]  w1_reg;
    logic [AIDX_W-1:0]  w2_reg;
    logic [WIDX_W-1:0]  wi_reg;
    logic [WIDX_W-1:0]  v1_reg;
    logic [WIDX_W-1:0]  v2_reg;
    logic [11:0]        a_lo_reg;
    logic [11:0]        a_hi_reg;
    logic [15:0]        w0_reg;
    logic [2:0]         step_reg;
    logic [15:0]        x1_reg;
    logic [15:0]        x2_reg;
    logic [15:0]        c11_reg;
    logic [15:0]        c21_reg;
    logic [15:0]        c12_reg;
    logic [15:0]        c22_reg;
    logic [1:0]         ph_reg;
    logic signed [V_W-1:0] s1_reg;
    logic signed [V_W-1:0] s2_reg;
    logic [15:0]        res_speed_reg;
    logic               res_valid_reg;
    logic               m_valid_reg;
    logic [15:0]        m_data_reg;
    logic               m_user_reg;

    // Input fields
    logic [1:0]  in_func;
    logic [5:0]  in_angle_slot;
    logic [4:0]  in_wind_slot;
    logic [15:0] in_write_value;
    logic [15:0] in_query_angle;
    logic [15:0] in_query_wind;
    logic        in_check;
    logic        in_accept;

    assign in_func        = s_axis_tuser;
    assign in_angle_slot  = s_axis_tdata[5:0];
    assign in_wind_slot   = s_axis_tdata[10:6];
    assign in_write_value = s_axis_tdata[26:11];
    assign in_query_angle = s_axis_tdata[42:27];
    assign in_query_wind  = s_axis_tdata[58:43];
    assign in_check       = s_axis_tdata[59];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Effective counts
    logic [6:0] na_eff;
    logic [5:0] nw_eff;
    assign na_eff = (int'(angle_count_reg) > MAX_ANGLES) ? 7'(MAX_ANGLES) : angle_count_reg;
    assign nw_eff = (int'(wind_count_reg) > MAX_WINDS) ? 6'(MAX_WINDS) : wind_count_reg;

    // Memory writes happen only at acceptance; reads follow in later states
    logic a_we;
    logic w_we;
    logic s_we;
    assign a_we = in_accept && (in_func == ptbs_pkg::FUNC_WR_ANGLE)
                  && (int'(in_angle_slot) < MAX_ANGLES);
    assign w_we = in_accept && (in_func == ptbs_pkg::FUNC_WR_WIND)
                  && (int'(in_wind_slot) < MAX_WINDS);
    assign s_we = in_accept && (in_func == ptbs_pkg::FUNC_WR_CELL)
                  && (int'(in_angle_slot) < MAX_ANGLES) && (int'(in_wind_slot) < MAX_WINDS);

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            angle_mem[AIDX_W'(in_angle_slot)] <=
                (in_write_value > 16'd4095) ? 12'hFFF : in_write_value[11:0];
        end
        a_rd_data <= angle_mem[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            wind_mem[WIDX_W'(in_wind_slot)] <= in_write_value;
        end
        w_rd_data <= wind_mem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            speed_mem[CA_W'(int'(in_wind_slot) * MAX_ANGLES + int'(in_angle_slot))]
                <= in_write_value;
        end
        s_rd_data <= speed_mem[s_raddr];
    end

    // Read addresses by state and fetch step
    always_comb
    begin
        case (state_reg)
            S_RD1:   a_raddr = na_last_reg;
            S_CHK:   a_raddr = AIDX_W'(1);
            S_ASCAN: a_raddr = AIDX_W'(w1_reg + 2'd2);
            default: a_raddr = '0;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_RD1:    w_raddr = nw_last_reg;
            S_WSTART: w_raddr = WIDX_W'(1);
            S_WSCAN:  w_raddr = WIDX_W'(wi_reg + 1'b1);
            S_FETCH:  w_raddr = (step_reg == 3'd0) ? v1_reg : v2_reg;
            default:  w_raddr = '0;
        endcase
    end

    always_comb
    begin
        case (step_reg)
            3'd0:    s_raddr = CA_W'(int'(v1_reg) * MAX_ANGLES + int'(w1_reg));
            3'd1:    s_raddr = CA_W'(int'(v2_reg) * MAX_ANGLES + int'(w1_reg));
            3'd2:    s_raddr = CA_W'(int'(v1_reg) * MAX_ANGLES + int'(w2_reg));
            default: s_raddr = CA_W'(int'(v2_reg) * MAX_ANGLES + int'(w2_reg));
        endcase
    end

    // Interpolation operands by phase
    logic signed [17:0]    lin_x;
    logic signed [17:0]    lin_xa;
    logic signed [17:0]    lin_xb;
    logic signed [V_W-1:0] lin_ya;
    logic signed [V_W-1:0] lin_yb;
    logic signed [V_W-1:0] lin_val;
    logic signed [V_W-1:0] res_clamp;
    logic                  lin_step;
    ptbs_pkg::md_req_t     md_req;
    ptbs_pkg::md_rsp_t     md_rsp;

    always_comb
    begin
        if (ph_reg == 2'd2)
        begin
            lin_x  = 18'(ang_reg);
            lin_xa = $signed({6'd0, a_lo_reg});
            lin_xb = $signed({6'd0, a_hi_reg});
            lin_ya = s1_reg;
            lin_yb = s2_reg;
        end
        else
        begin
            lin_x  = $signed({3'd0, qw_reg});
            lin_xa = $signed({2'd0, x1_reg});
            lin_xb = $signed({2'd0, x2_reg});
            lin_ya = (ph_reg == 2'd0) ? $signed(V_W'(c11_reg)) : $signed(V_W'(c12_reg));
            lin_yb = (ph_reg == 2'd0) ? $signed(V_W'(c21_reg)) : $signed(V_W'(c22_reg));
        end
    end

    assign md_req.start = (state_reg == S_LIN) && (lin_xb != lin_xa);
    assign md_req.a     = ptbs_pkg::A_W'(lin_yb - lin_ya);
    assign md_req.b     = ptbs_pkg::B_W'(lin_x - lin_xa);
    assign md_req.d     = ptbs_pkg::D_W'(lin_xb - lin_xa);

    assign lin_val  = (state_reg == S_LIN) ? lin_ya : md_rsp.q + lin_ya;
    assign lin_step = ((state_reg == S_LIN) && (lin_xb == lin_xa))
                      || ((state_reg == S_WAIT) && md_rsp.done);

    // Clamp the final result into Q8.8 range
    always_comb
    begin
        if (lin_val < 0)
            res_clamp = '0;
        else if (lin_val > $signed(V_W'(65535)))
            res_clamp = V_W'(65535);
        else
            res_clamp = lin_val;
    end

    ptbs_muldiv u_muldiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_count_reg <= 7'd1;
            wind_count_reg  <= 6'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                ptbs_pkg::CFG_ANGLE_COUNT: angle_count_reg <= cfg_wdata;
                ptbs_pkg::CFG_WIND_COUNT:  wind_count_reg  <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop the output once taken, unless a new result loads it
            if (m_valid_reg && m_axis_tready && state_reg != S_DONE)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        res_speed_reg <= '0;
                        res_valid_reg <= 1'b0;
                        ang_reg       <= 17'($signed(in_query_angle));
                        qw_reg        <= in_query_wind[14:0];
                        chk_reg       <= in_check;
                        na_last_reg   <= AIDX_W'(na_eff - 7'd1);
                        nw_last_reg   <= WIDX_W'(nw_eff - 6'd1);
                        if (in_func != ptbs_pkg::FUNC_QUERY || in_query_wind[15]
                            || na_eff == 7'd0 || nw_eff == 6'd0)
                            state_reg <= S_DONE;
                        else
                            state_reg <= S_WRAP;
                    end
                end
                S_WRAP:
                begin
                    if (ang_reg < 0)
                        ang_reg <= ang_reg + ptbs_pkg::ANG_FULL;
                    else if (ang_reg >= ptbs_pkg::ANG_FULL)
                        ang_reg <= ang_reg - ptbs_pkg::ANG_FULL;
                    else
                    begin
                        if (ang_reg > ptbs_pkg::ANG_HALF)
                            ang_reg <= ptbs_pkg::ANG_FULL - ang_reg;
                        state_reg <= S_RD0;
                    end
                end
                S_RD0:
                begin
                    state_reg <= S_RD1;
                end
                S_RD1:
                begin
                    a_lo_reg  <= a_rd_data;
                    a_hi_reg  <= a_rd_data;
                    w0_reg    <= w_rd_data;
                    w1_reg    <= '0;
                    w2_reg    <= '0;
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    // Drop queries outside the angle axis or, if checked, the wind axis
                    if (ang_reg[11:0] < a_lo_reg || ang_reg[11:0] > a_rd_data
                        || (chk_reg && ({1'b0, qw_reg} < w0_reg
                                        || {1'b0, qw_reg} > w_rd_data)))
                        state_reg <= S_DONE;
                    else if (na_last_reg != '0)
                        state_reg <= S_ASCAN;
                    else
                        state_reg <= S_WSTART;
                end
                S_ASCAN:
                begin
                    if ({ang_reg[11:4], 4'd0} > a_rd_data)
                    begin
                        a_lo_reg <= a_rd_data;
                        a_hi_reg <= a_rd_data;
                        w1_reg   <= AIDX_W'(w1_reg + 1'b1);
                        if (AIDX_W'(w1_reg + 1'b1) >= na_last_reg)
                        begin
                            w2_reg    <= AIDX_W'(w1_reg + 1'b1);
                            state_reg <= S_WSTART;
                        end
                    end
                    else
                    begin
                        a_hi_reg  <= a_rd_data;
                        w2_reg    <= AIDX_W'(w1_reg + 1'b1);
                        state_reg <= S_WSTART;
                    end
                end
                S_WSTART:
                begin
                    step_reg <= '0;
                    if (nw_last_reg > WIDX_W'(1))
                    begin
                        wi_reg    <= WIDX_W'(1);
                        state_reg <= S_WSCAN;
                    end
                    else
                    begin
                        v1_reg    <= '0;
                        v2_reg    <= nw_last_reg;
                        state_reg <= S_FETCH;
                    end
                end
                S_WSCAN:
                begin
                    if (w_rd_data > {1'b0, qw_reg})
                    begin
                        v1_reg    <= WIDX_W'(wi_reg - 1'b1);
                        v2_reg    <= wi_reg;
                        state_reg <= S_FETCH;
                    end
                    else if (WIDX_W'(wi_reg + 1'b1) < nw_last_reg)
                    begin
                        wi_reg <= WIDX_W'(wi_reg + 1'b1);
                    end
                    else
                    begin
                        v1_reg    <= WIDX_W'(nw_last_reg - 1'b1);
                        v2_reg    <= nw_last_reg;
                        state_reg <= S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    step_reg <= step_reg + 1'b1;
                    case (step_reg)
                        3'd1:
                        begin
                            x1_reg  <= w_rd_data;
                            c11_reg <= s_rd_data;
                        end
                        3'd2:
                        begin
                            x2_reg  <= w_rd_data;
                            c21_reg <= s_rd_data;
                        end
                        3'd3:
                        begin
                            c12_reg <= s_rd_data;
                        end
                        3'd4:
                        begin
                            c22_reg   <= s_rd_data;
                            ph_reg    <= 2'd0;
                            state_reg <= S_LIN;
                        end
                        default: ;
                    endcase
                end
                S_LIN, S_WAIT:
                begin
                    if (state_reg == S_LIN && md_req.start)
                        state_reg <= S_WAIT;
                    if (lin_step)
                    begin
                        ph_reg <= ph_reg + 1'b1;
                        case (ph_reg)
                            2'd0:
                            begin
                                s1_reg    <= lin_val;
                                state_reg <= S_LIN;
                            end
                            2'd1:
                            begin
                                s2_reg    <= lin_val;
                                state_reg <= S_LIN;
                            end
                            default:
                            begin
                                res_speed_reg <= res_clamp[15:0];
                                res_valid_reg <= 1'b1;
                                state_reg     <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DONE:
                begin
                    // Hold the result until the output register is free
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_speed_reg;
                        m_user_reg  <= res_valid_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_user_reg;

    `PTBS_ASSERT_IMPL(a_done_in_wait, md_rsp.done, state_reg == S_WAIT)
    `PTBS_ASSERT_NEXT(a_busy_after_accept, in_accept, state_reg != S_IDLE)
    `PTBS_ASSERT_IMPL(a_invalid_is_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 16'd0)

endmodule

>>> src/ptbs_muldiv.sv
// Shared sequential unit: q = a * b / d, truncated toward zero.
module ptbs_muldiv
(
    input  logic              clk,
    input  logic              rst_n,
    input  ptbs_pkg::md_req_t req,
    output ptbs_pkg::md_rsp_t rsp
);

    localparam int A_W   = ptbs_pkg::A_W;
    localparam int B_W   = ptbs_pkg::B_W;
    localparam int D_W   = ptbs_pkg::D_W;
    localparam int P_W   = ptbs_pkg::P_W;
    localparam int V_W   = ptbs_pkg::V_W;
    localparam int CNT_W = $clog2(P_W);

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} md_state_t;

    md_state_t             state_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [P_W-1:0]        am_reg;
    logic [B_W-1:0]        bm_reg;
    logic [D_W-1:0]        dm_reg;
    logic [P_W-1:0]        acc_reg;
    logic [D_W-1:0]        rem_reg;
    logic                  neg_reg;
    logic                  done_reg;
    logic signed [V_W-1:0] q_reg;

    logic [A_W-1:0] a_mag;
    logic [B_W-1:0] b_mag;
    logic [D_W-1:0] d_mag;
    logic [D_W:0]   shifted;
    logic [D_W:0]   trial;
    logic           q_bit;
    logic [P_W-1:0] qm;

    // Operand magnitudes
    assign a_mag = req.a[A_W-1] ? A_W'(-req.a) : A_W'(req.a);
    assign b_mag = req.b[B_W-1] ? B_W'(-req.b) : B_W'(req.b);
    assign d_mag = req.d[D_W-1] ? D_W'(-req.d) : D_W'(req.d);

    // One restoring division step
    assign shifted = {rem_reg, acc_reg[P_W-1]};
    assign trial   = shifted - {1'b0, dm_reg};
    assign q_bit   = (shifted >= {1'b0, dm_reg});
    assign qm      = {acc_reg[P_W-2:0], q_bit};

    // Shift-add multiply, then one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE:
                begin
                    if (req.start)
                    begin
                        am_reg    <= P_W'(a_mag);
                        bm_reg    <= b_mag;
                        dm_reg    <= d_mag;
                        neg_reg   <= req.a[A_W-1] ^ req.b[B_W-1] ^ req.d[D_W-1];
                        acc_reg   <= '0;
                        cnt_reg   <= CNT_W'(B_W - 1);
                        state_reg <= M_MUL;
                    end
                end
                M_MUL:
                begin
                    if (bm_reg[0])
                    begin
                        acc_reg <= acc_reg + am_reg;
                    end
                    am_reg  <= am_reg << 1;
                    bm_reg  <= bm_reg >> 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        cnt_reg   <= CNT_W'(P_W - 1);
                        rem_reg   <= '0;
                        state_reg <= M_DIV;
                    end
                end
                M_DIV:
                begin
                    rem_reg <= q_bit ? trial[D_W-1:0] : shifted[D_W-1:0];
                    acc_reg <= qm;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        q_reg     <= neg_reg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
                        done_reg  <= 1'b1;
                        state_reg <= M_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;

endmodule
